// ===== sv/indexed_vector_store_unit_defines.svh =====
// Assertion macros shared by the checker of the indexed vector store unit.
`ifndef INDEXED_VECTOR_STORE_UNIT_DEFINES_SVH
`define INDEXED_VECTOR_STORE_UNIT_DEFINES_SVH

// Checks a condition at every rising edge outside reset.
`define IVS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger in one cycle is followed by a condition in the next cycle.
`define IVS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== sv/ivs_pkg.sv =====
// Package with the item types, action codes and control structs of the vector store.
`default_nettype none
package ivs_pkg;

  // Field widths of the item formats.
  localparam int IDX_W  = 11;
  localparam int DATA_W = 64;
  localparam int ACT_W  = 3;

  // Default number of entries in the store.
  localparam int CAPACITY_DEF = 1024;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd5;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One input item.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] item_value;
  } ivs_in_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] read_value;
    logic [IDX_W-1:0]  fill_count;
  } ivs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_en;
    logic shift_en;
    logic ins_wr;
  } ivs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic shift_start;
    logic shift_last;
  } ivs_sts_t;

endpackage
`default_nettype wire

// ===== sv/ivs_ctrl.sv =====
// Controller state machine of the vector store: clearing pass, idle and insert shift.
`default_nettype none
module ivs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire ivs_pkg::ivs_sts_t sts,
  output ivs_pkg::ivs_cmd_t     cmd
);
  import ivs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_INSWR = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Items are taken only in the idle state.
  assign busy = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = start;
        if (start && sts.shift_start) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (sts.shift_last) begin
          state_nxt = ST_INSWR;
        end
      end
      ST_INSWR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ivs_datapath.sv =====
// Datapath of the vector store: entry memory, fill count, shift pointer and result registers.
`default_nettype none
module ivs_datapath #(
  parameter int CAPACITY = ivs_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ivs_pkg::ivs_in_t  in_item,
  input  wire ivs_pkg::ivs_cmd_t cmd,
  output ivs_pkg::ivs_sts_t      sts,
  output logic                   out_strobe,
  output ivs_pkg::ivs_out_t      out_item
);
  import ivs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  // Entry memory with registered read data.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_nxt;
  logic [AW-1:0]     op_idx_r;
  logic [DATA_W-1:0] op_val_r;

  logic              strobe_r;
  logic              strobe_nxt;
  logic              status_r;
  logic              status_nxt;
  logic              rd_flag_r;
  logic              rd_flag_nxt;

  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     cnt_x;
  logic              full;
  logic              empty;
  logic              idx_below;
  logic              ins_shift;

  // Bounds checks on the incoming item against the fill count.
  assign idx_x     = XW'(in_item.index);
  assign cnt_x     = XW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign idx_below = (idx_x < cnt_x);
  assign ins_shift = (in_item.action == ACT_INSERT) && idx_below && !full;

  assign sts.clr_done    = (clr_addr_r == AW'(CAPACITY - 1));
  assign sts.shift_start = ins_shift;
  assign sts.shift_last  = (ptr_r == op_idx_r);

  // Memory port steering and next state of the count and result.
  always_comb begin
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    rd_flag_nxt = rd_flag_r;
    if (cmd.clr_en) begin
      we    = 1'b1;
      waddr = clr_addr_r;
    end else if (cmd.shift_en) begin
      // Move the entry read last cycle up by one, then fetch the one below.
      we    = 1'b1;
      waddr = AW'(ptr_r + 1'b1);
      wdata = rdata_r;
      if (!sts.shift_last) begin
        re      = 1'b1;
        raddr   = AW'(ptr_r - 1'b1);
        ptr_nxt = AW'(ptr_r - 1'b1);
      end
    end else if (cmd.ins_wr) begin
      we          = 1'b1;
      waddr       = op_idx_r;
      wdata       = op_val_r;
      count_nxt   = CW'(count_r + 1'b1);
      strobe_nxt  = 1'b1;
      status_nxt  = STATUS_OK;
      rd_flag_nxt = 1'b0;
    end else if (cmd.accept) begin
      strobe_nxt  = 1'b1;
      status_nxt  = STATUS_ERR;
      rd_flag_nxt = 1'b0;
      case (in_item.action)
        ACT_PUSH: begin
          if (!full) begin
            we         = 1'b1;
            waddr      = AW'(count_r);
            wdata      = in_item.item_value;
            count_nxt  = CW'(count_r + 1'b1);
            status_nxt = STATUS_OK;
          end
        end
        ACT_POP: begin
          if (!empty) begin
            re          = 1'b1;
            raddr       = AW'(count_r - 1'b1);
            count_nxt   = CW'(count_r - 1'b1);
            status_nxt  = STATUS_OK;
            rd_flag_nxt = 1'b1;
          end
        end
        ACT_INSERT: begin
          if (ins_shift) begin
            // Shift pass starts at the last entry; the result comes later.
            strobe_nxt = 1'b0;
            re         = 1'b1;
            raddr      = AW'(count_r - 1'b1);
            ptr_nxt    = AW'(count_r - 1'b1);
          end else if (!full && idx_x == cnt_x) begin
            we         = 1'b1;
            waddr      = AW'(count_r);
            wdata      = in_item.item_value;
            count_nxt  = CW'(count_r + 1'b1);
            status_nxt = STATUS_OK;
          end
        end
        ACT_GET: begin
          if (idx_below) begin
            re          = 1'b1;
            raddr       = AW'(in_item.index);
            status_nxt  = STATUS_OK;
            rd_flag_nxt = 1'b1;
          end
        end
        ACT_SET: begin
          if (idx_below) begin
            we         = 1'b1;
            waddr      = AW'(in_item.index);
            wdata      = in_item.item_value;
            status_nxt = STATUS_OK;
          end
        end
        ACT_RESIZE: begin
          if (idx_x <= XW'(CAPACITY)) begin
            count_nxt  = CW'(idx_x);
            status_nxt = STATUS_OK;
          end
        end
        default: begin
          status_nxt = STATUS_ERR;
        end
      endcase
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Captured operation and shift pointer.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.accept) begin
      op_idx_r <= AW'(in_item.index);
      op_val_r <= in_item.item_value;
    end
    status_r  <= status_nxt;
    rd_flag_r <= rd_flag_nxt;
  end

  // Control registers: count, clear address and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      clr_addr_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      if (cmd.clr_en) begin
        clr_addr_r <= AW'(clr_addr_r + 1'b1);
      end
    end
  end

  // Result item; the count register holds the value after the operation.
  assign out_strobe          = strobe_r;
  assign out_item.status     = status_r;
  assign out_item.read_value = rd_flag_r ? rdata_r : '0;
  assign out_item.fill_count = IDX_W'(count_r);

endmodule
`default_nettype wire

// ===== sv/indexed_vector_store_unit.sv =====
// Top level of the indexed vector store unit.
// An item is taken on a clock edge where start is high and busy is low. Its result shows on
// out_item for exactly one cycle, flagged by out_strobe, and the receiver cannot hold it off.
// Push, pop, get, set, resize, appending inserts and rejected operations answer in the cycle
// after they are taken, so a new item may follow in the very next cycle. An insert below the
// fill count shifts the entries one per cycle through the memory's write and read ports: busy
// stays high through the shift and insert-write states and the result follows the last write.
// After reset the entry memory is cleared one entry per cycle, so busy stays high until every
// entry is cleared, and no item can be taken before then.
`default_nettype none
module indexed_vector_store_unit #(
  parameter int CAPACITY = ivs_pkg::CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire ivs_pkg::ivs_in_t in_item,
  output logic                  out_strobe,
  output ivs_pkg::ivs_out_t     out_item
);
  import ivs_pkg::*;

  ivs_cmd_t cmd;
  ivs_sts_t sts;

  // Sequencer.
  ivs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage and result path.
  ivs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

// ===== sv/ivs_checker.sv =====
// Port-level checker of the indexed vector store unit and its bind statement.
`default_nettype none
`include "indexed_vector_store_unit_defines.svh"
module ivs_checker #(
  parameter int CAPACITY = ivs_pkg::CAPACITY_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire ivs_pkg::ivs_in_t  in_item,
  input wire logic              out_strobe,
  input wire ivs_pkg::ivs_out_t out_item
);
  import ivs_pkg::*;

  logic accepted;
  logic simple_op;
  logic count_ok;
  logic err_result;

  assign accepted   = start && !busy;
  assign simple_op  = accepted && (in_item.action != ACT_INSERT);
  assign count_ok   = (32'(out_item.fill_count) <= CAPACITY);
  assign err_result = out_strobe && (out_item.status == STATUS_ERR);

  // Every item other than an insert answers in the next cycle.
  `IVS_ASSERT_NEXT(a_one_cycle_result, simple_op, out_strobe, "missing result item")
  // A result never appears while the unit is still busy.
  `IVS_ASSERT_ALWAYS(a_no_result_busy, !(out_strobe && busy), "result item during busy")
  // The fill count never exceeds the capacity.
  `IVS_ASSERT_ALWAYS(a_count_bound, !out_strobe || count_ok, "fill count beyond capacity")
  // A rejected operation returns no data.
  `IVS_ASSERT_ALWAYS(a_err_zero, !err_result || out_item.read_value == '0, "data on error")

endmodule

bind indexed_vector_store_unit ivs_checker #(
  .CAPACITY (CAPACITY)
) u_ivs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire
